// ===== design/bfa_pkg.sv =====
// Shared types and codes for the block-fit allocator.
package bfa_pkg;

  // Search policy codes; the unused code behaves as first fit
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIT_POLICY    = 2'd0;
  localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam int unsigned CfgDataW = 4;
  localparam int unsigned PolicyW  = 2;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Engine states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } eng_state_e;

  // Control half of the search token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic have;
  } tok_ctrl_t;

endpackage

// ===== design/bfa_cell.sv =====
// One table entry of the allocator plus its stage of the search chain.
module bfa_cell #(
  parameter int unsigned IdxW     = 3,
  parameter int unsigned SizeW    = 16,
  parameter int unsigned CellIdx  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // broadcast write port
  input  logic                          wr_en_i,
  input  logic [IdxW-1:0]               wr_idx_i,
  input  logic [SizeW-1:0]              wr_data_i,
  // search settings
  input  logic [bfa_pkg::PolicyW-1:0]   policy_i,
  input  logic [bfa_pkg::CfgDataW-1:0]  limit_i,
  // token from the previous cell
  input  bfa_pkg::tok_ctrl_t            tok_i,
  input  logic [IdxW-1:0]               sel_i,
  input  logic [SizeW-1:0]              sel_size_i,
  input  logic [SizeW-1:0]              req_i,
  // token to the next cell
  output bfa_pkg::tok_ctrl_t            tok_o,
  output logic [IdxW-1:0]               sel_o,
  output logic [SizeW-1:0]              sel_size_o,
  output logic [SizeW-1:0]              req_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [SizeW-1:0]   size_q;
  logic               in_use;
  logic               fits;
  logic               take;
  bfa_pkg::tok_ctrl_t tok_q, tok_d;
  logic [IdxW-1:0]    sel_q, sel_d;
  logic [SizeW-1:0]   sel_size_q, sel_size_d;
  logic [SizeW-1:0]   req_q;

  // stored remaining size, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (wr_en_i && (wr_idx_i == MyIdx)) begin
      size_q <= wr_data_i;
    end
  end

  // compare this entry against the best candidate so far
  assign in_use = (CellIdx < int'(limit_i));
  assign fits   = in_use && (size_q >= req_i);

  always_comb begin
    take = 1'b0;
    if (!tok_i.have) begin
      take = fits;
    end else begin
      case (bfa_pkg::fit_policy_e'(policy_i))
        bfa_pkg::FIT_BEST:  take = fits && (size_q < sel_size_i);
        bfa_pkg::FIT_WORST: take = fits && (size_q > sel_size_i);
        default:            take = 1'b0;
      endcase
    end
  end

  always_comb begin
    tok_d.valid = tok_i.valid;
    tok_d.have  = tok_i.have | fits;
    sel_d       = take ? MyIdx  : sel_i;
    sel_size_d  = take ? size_q : sel_size_i;
  end

  // token stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q      <= sel_d;
    sel_size_q <= sel_size_d;
    req_q      <= req_i;
  end

  assign tok_o      = tok_q;
  assign sel_o      = sel_q;
  assign sel_size_o = sel_size_q;
  assign req_o      = req_q;

endmodule

// ===== design/block_fit_allocator_core.sv =====
// Block-fit allocator: a chain of table cells searched by a travelling token.
//
// Input channel (in_valid_i/in_ready_o) carries opcode_i, block_index_i and
// size_value_i. A load writes one table entry and returns its result in the
// cycle after acceptance. An allocate launches a search token that walks the
// cell chain one cell per cycle; its result passes through the launch register,
// the token register of every cell and the output register. One item is in
// the engine at a time, so a new item is not accepted until the previous one
// has finished.
// Output channel (out_valid_o/out_ready_i) carries found_o, chosen_block_o
// and remaining_size_o from an output register. A new transaction is taken
// in the cycle the previous result leaves; while the receiver stalls the
// result holds and no new item is accepted.
// Configuration port (cfg_valid_i/cfg_ready_o) writes fit_policy (index 0)
// and blocks_in_use (index 1); it is always ready and must be used only
// while the block is idle.
// Reset clears every table entry to zero, sets fit_policy to first fit and
// blocks_in_use to 8, and empties the engine and the output register.
module block_fit_allocator_core #(
  parameter int unsigned NUM_BLOCKS = 8,
  parameter int unsigned SIZE_BITS  = 16,
  localparam int unsigned IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [bfa_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [IdxW-1:0]               block_index_i,
  input  logic [SIZE_BITS-1:0]          size_value_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [IdxW-1:0]               chosen_block_o,
  output logic [SIZE_BITS-1:0]          remaining_size_o
);

  logic [bfa_pkg::PolicyW-1:0]  policy_q;
  logic [bfa_pkg::CfgDataW-1:0] limit_q;

  bfa_pkg::eng_state_e state_q, state_d;
  logic                in_acc;
  logic                start_search;
  logic                load_ok;
  logic                done;
  logic                launch_q;
  logic [SIZE_BITS-1:0] req_q;

  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;
  logic [SIZE_BITS-1:0] wr_data;

  logic                 out_valid_q;
  logic                 found_q;
  logic [IdxW-1:0]      chosen_q;
  logic [SIZE_BITS-1:0] rem_q;
  logic [SIZE_BITS-1:0] alloc_left;

  bfa_pkg::tok_ctrl_t   tok  [NUM_BLOCKS+1];
  logic [IdxW-1:0]      sel  [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] selsz[NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] req  [NUM_BLOCKS+1];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= bfa_pkg::FIT_FIRST;
      limit_q  <= bfa_pkg::CfgDataW'(8);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfa_pkg::CFG_FIT_POLICY:    policy_q <= cfg_data_i[bfa_pkg::PolicyW-1:0];
        bfa_pkg::CFG_BLOCKS_IN_USE: limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // engine state machine: next state
  assign in_acc = in_valid_i && in_ready_o;
  assign done   = tok[NUM_BLOCKS].valid;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfa_pkg::ST_IDLE:   if (in_acc && (opcode_i == bfa_pkg::OP_ALLOC)) state_d = bfa_pkg::ST_SEARCH;
      bfa_pkg::ST_SEARCH: if (done) state_d = bfa_pkg::ST_IDLE;
      default:            state_d = bfa_pkg::ST_IDLE;
    endcase
  end

  // engine state machine: outputs
  always_comb begin
    in_ready_o   = 1'b0;
    start_search = 1'b0;
    unique case (state_q)
      bfa_pkg::ST_IDLE: begin
        in_ready_o   = !out_valid_q || out_ready_i;
        start_search = in_acc && (opcode_i == bfa_pkg::OP_ALLOC);
      end
      bfa_pkg::ST_SEARCH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bfa_pkg::ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= start_search;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_search) begin
      req_q <= size_value_i;
    end
  end

  // token into the head of the chain
  assign tok[0].valid = launch_q;
  assign tok[0].have  = 1'b0;
  assign sel[0]       = '0;
  assign selsz[0]     = '0;
  assign req[0]       = req_q;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    bfa_cell #(
      .IdxW    (IdxW),
      .SizeW   (SIZE_BITS),
      .CellIdx (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en),
      .wr_idx_i   (wr_idx),
      .wr_data_i  (wr_data),
      .policy_i   (policy_q),
      .limit_i    (limit_q),
      .tok_i      (tok[g]),
      .sel_i      (sel[g]),
      .sel_size_i (selsz[g]),
      .req_i      (req[g]),
      .tok_o      (tok[g+1]),
      .sel_o      (sel[g+1]),
      .sel_size_o (selsz[g+1]),
      .req_o      (req[g+1])
    );
  end

  // table write: load on acceptance, allocation writeback at search end
  assign load_ok    = (int'(block_index_i) < NUM_BLOCKS);
  assign alloc_left = selsz[NUM_BLOCKS] - req[NUM_BLOCKS];

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = block_index_i;
    wr_data = size_value_i;
    if (done) begin
      wr_en   = tok[NUM_BLOCKS].have;
      wr_idx  = sel[NUM_BLOCKS];
      wr_data = alloc_left;
    end else if (in_acc && (opcode_i == bfa_pkg::OP_LOAD)) begin
      wr_en = load_ok;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done || (in_acc && (opcode_i == bfa_pkg::OP_LOAD))) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      found_q  <= tok[NUM_BLOCKS].have;
      chosen_q <= tok[NUM_BLOCKS].have ? sel[NUM_BLOCKS] : '0;
      rem_q    <= tok[NUM_BLOCKS].have ? alloc_left : '0;
    end else if (in_acc && (opcode_i == bfa_pkg::OP_LOAD)) begin
      found_q  <= 1'b0;
      chosen_q <= block_index_i;
      rem_q    <= load_ok ? size_value_i : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign chosen_block_o   = chosen_q;
  assign remaining_size_o = rem_q;

endmodule

// ===== design/bfa_checker.sv =====
// Port-level checks for the block-fit allocator, bound to the top level.
module bfa_checker #(
  parameter int unsigned NUM_BLOCKS = 8,
  parameter int unsigned SIZE_BITS  = 16,
  localparam int unsigned IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 opcode_i,
  input logic [IdxW-1:0]      block_index_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 found_o,
  input logic [IdxW-1:0]      chosen_block_o,
  input logic [SIZE_BITS-1:0] remaining_size_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
      && $stable(chosen_block_o) && $stable(remaining_size_o))
    else $error("stalled result changed");

  // a load transaction answers in the next cycle with its own index
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == bfa_pkg::OP_LOAD) |=>
      out_valid_o && !found_o && (chosen_block_o == $past(block_index_i)))
    else $error("load result missing or wrong");

  // an allocate result never appears the cycle after acceptance
  a_alloc_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == bfa_pkg::OP_ALLOC) |=> !out_valid_o)
    else $error("allocate result too early");

  // input is only taken when the output register frees up
  a_ready_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_ready_i)
    else $error("input taken while result stalled");

endmodule

bind block_fit_allocator_core bfa_checker #(
  .NUM_BLOCKS (NUM_BLOCKS),
  .SIZE_BITS  (SIZE_BITS)
) u_bfa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .opcode_i         (opcode_i),
  .block_index_i    (block_index_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .found_o          (found_o),
  .chosen_block_o   (chosen_block_o),
  .remaining_size_o (remaining_size_o)
);

// ===== verif/block_fit_allocator_core_tb.sv =====
// Testbench for block_fit_allocator_core: directed table, random traffic, in-order result checks.
module block_fit_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BLOCKS   = 8;
  localparam int unsigned SIZE_BITS    = 16;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned DRAIN_CYCLES = NUM_BLOCKS + 4;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned NUM_DIR      = 26;
  localparam int unsigned NUM_SEGS     = 10;
  localparam int unsigned SEG_ITEMS    = 105;
  localparam int unsigned HOLD_SEG     = 7;
  localparam int unsigned PAUSE_SEG    = 8;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     chosen;
    logic [SIZE_BITS-1:0] rem;
  } alloc_result_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  // One line of the directed table; reg_sel/val carry a register write on ROW_CFG
  typedef struct packed {
    row_kind_e            kind;
    logic [1:0]           reg_sel;
    logic                 op;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] val;
    logic                 typed;
    logic                 found;
    logic [IDX_W-1:0]     chosen;
    logic [SIZE_BITS-1:0] rem;
  } stim_row_t;

  // DUT connections
  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         cfg_valid_i      = 1'b0;
  logic                         cfg_ready_o;
  logic [1:0]                   cfg_index_i      = '0;
  logic [bfa_pkg::CfgDataW-1:0] cfg_data_i       = '0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_ready_o;
  logic                         opcode_i         = bfa_pkg::OP_LOAD;
  logic [IDX_W-1:0]             block_index_i    = '0;
  logic [SIZE_BITS-1:0]         size_value_i     = '0;
  logic                         out_valid_o;
  logic                         out_ready_i      = 1'b0;
  logic                         found_o;
  logic [IDX_W-1:0]             chosen_block_o;
  logic [SIZE_BITS-1:0]         remaining_size_o;

  // Shadow of the allocator state
  logic [SIZE_BITS-1:0]         block_tbl [NUM_BLOCKS];
  logic [bfa_pkg::PolicyW-1:0]  cur_policy;
  logic [bfa_pkg::CfgDataW-1:0] cur_biu;

  alloc_result_t expected_results [$];
  int unsigned   fail_cnt      = 0;
  int unsigned   cycle_cnt     = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  logic          hold_off_go   = 1'b0;

  // Register settings per random segment, extremes included
  logic [1:0]                   seg_policy [NUM_SEGS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                                          2'd2, 2'd0, 2'd1, 2'd2, 2'd1};
  logic [bfa_pkg::CfgDataW-1:0] seg_biu [NUM_SEGS]    = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5,
                                                          4'd8, 4'd3, 4'd8, 4'd6, 4'd8};

  // Directed table: typed expectations only where obvious, else predictor-checked
  stim_row_t dir_rows [NUM_DIR] = '{
    // zero request fits an empty block after reset
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd0,     1'b1, 1'b1, 3'd0, 16'd0},
    // nothing fits after reset
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd1,     1'b1, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'hFFFF,  1'b1, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_LOAD,  3'd7, 16'hFFFF,  1'b1, 1'b0, 3'd7, 16'hFFFF},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_LOAD,  3'd0, 16'd0,     1'b1, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_LOAD,  3'd1, 16'd100,   1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_LOAD,  3'd2, 16'd50,    1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_LOAD,  3'd3, 16'd200,   1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_LOAD,  3'd4, 16'd50,    1'b0, 1'b0, 3'd0, 16'd0},
    // full-size request drains the only full block
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'hFFFF,  1'b1, 1'b1, 3'd7, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd30,    1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_CFG,  bfa_pkg::CFG_FIT_POLICY, bfa_pkg::OP_LOAD, 3'd0, 16'(bfa_pkg::FIT_BEST),
      1'b0, 1'b0, 3'd0, 16'd0},
    // best fit with a tie between two equal blocks
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd40,    1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd0,     1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_CFG,  bfa_pkg::CFG_FIT_POLICY, bfa_pkg::OP_LOAD, 3'd0, 16'(bfa_pkg::FIT_WORST),
      1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd10,    1'b0, 1'b0, 3'd0, 16'd0},
    // undefined policy code, upper data bits set
    '{ROW_CFG,  bfa_pkg::CFG_FIT_POLICY, bfa_pkg::OP_LOAD, 3'd0, 16'd15,
      1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd5,     1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_CFG,  bfa_pkg::CFG_BLOCKS_IN_USE, bfa_pkg::OP_LOAD, 3'd0, 16'd0,
      1'b0, 1'b0, 3'd0, 16'd0},
    // no entry considered
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd0,     1'b1, 1'b0, 3'd0, 16'd0},
    '{ROW_CFG,  bfa_pkg::CFG_BLOCKS_IN_USE, bfa_pkg::OP_LOAD, 3'd0, 16'd15,
      1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_LOAD,  3'd7, 16'd9,     1'b1, 1'b0, 3'd7, 16'd9},
    // oversized count, every entry still in use
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd9,     1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_CFG,  bfa_pkg::CFG_BLOCKS_IN_USE, bfa_pkg::OP_LOAD, 3'd0, 16'd1,
      1'b0, 1'b0, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd0,     1'b1, 1'b1, 3'd0, 16'd0},
    '{ROW_ITEM, 2'd0, bfa_pkg::OP_ALLOC, 3'd0, 16'd1,     1'b1, 1'b0, 3'd0, 16'd0}
  };

  block_fit_allocator_core #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .block_index_i    (block_index_i),
    .size_value_i     (size_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .chosen_block_o   (chosen_block_o),
    .remaining_size_o (remaining_size_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Allocation predictor: updates the shadow table and returns the result
  function automatic alloc_result_t predict_alloc(input logic op, input logic [IDX_W-1:0] idx,
                                                  input logic [SIZE_BITS-1:0] req);
    alloc_result_t res;
    int unsigned   span;
    bit            have;
    int unsigned   sel;
    res  = '0;
    have = 1'b0;
    sel  = 0;
    if (op == bfa_pkg::OP_LOAD) begin
      block_tbl[idx] = req;
      res.chosen     = idx;
      res.rem        = req;
    end else begin
      span = (cur_biu > NUM_BLOCKS) ? NUM_BLOCKS : cur_biu;
      for (int j = 0; j < span; j++) begin
        if (block_tbl[j] >= req) begin
          if (!have) begin
            have = 1'b1;
            sel  = j;
            if (cur_policy != bfa_pkg::FIT_BEST && cur_policy != bfa_pkg::FIT_WORST) break;
          end else if (cur_policy == bfa_pkg::FIT_BEST && block_tbl[j] < block_tbl[sel]) begin
            sel = j;
          end else if (cur_policy == bfa_pkg::FIT_WORST && block_tbl[j] > block_tbl[sel]) begin
            sel = j;
          end
        end
      end
      if (have) begin
        block_tbl[sel] = block_tbl[sel] - req;
        res.found      = 1'b1;
        res.chosen     = IDX_W'(sel);
        res.rem        = block_tbl[sel];
      end
    end
    return res;
  endfunction

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [SIZE_BITS-1:0] sz, input bit typed,
                           input alloc_result_t typed_res);
    alloc_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    block_index_i <= idx;
    size_value_i  <= sz;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_alloc(op, idx, sz);
    expected_results.push_back(typed ? typed_res : res);
  endtask

  // Register write transaction; valid is dropped before the task returns
  task automatic write_reg(input logic [1:0] sel, input logic [bfa_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (sel == bfa_pkg::CFG_FIT_POLICY) cur_policy = data[bfa_pkg::PolicyW-1:0];
    else if (sel == bfa_pkg::CFG_BLOCKS_IN_USE) cur_biu = data;
    @(posedge clk_i);
  endtask

  // Stop offering and let the engine drain completely
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic                 op;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] sz;
    foreach (block_tbl[j]) block_tbl[j] = '0;
    cur_policy = bfa_pkg::FIT_FIRST;
    cur_biu    = 4'd8;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[r].reg_sel, dir_rows[r].val[bfa_pkg::CfgDataW-1:0]);
      end else begin
        send_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].typed,
                  '{dir_rows[r].found, dir_rows[r].chosen, dir_rows[r].rem});
      end
    end

    // random segments, each under its own register setting and one of three idle patterns
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_idle();
      write_reg(bfa_pkg::CFG_FIT_POLICY, {2'($urandom_range(0, 3)), seg_policy[seg]});
      write_reg(bfa_pkg::CFG_BLOCKS_IN_USE, seg_biu[seg]);
      if (seg < 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 73;
      end else if (seg < 6) begin
        send_idle_pct = 73;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == HOLD_SEG) hold_off_go <= 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // sender pause until every result is back
        if (seg == PAUSE_SEG && n == SEG_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (expected_results.size() != 0) @(posedge clk_i);
        end
        idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
        if ($urandom_range(0, 99) < 35) begin
          op = bfa_pkg::OP_LOAD;
          case ($urandom_range(0, 9))
            0:       sz = '0;
            1:       sz = '1;
            2, 3:    sz = SIZE_BITS'(16 << $urandom_range(0, 2));
            4, 5, 6: sz = SIZE_BITS'($urandom_range(0, 255));
            default: sz = SIZE_BITS'($urandom);
          endcase
        end else begin
          op = bfa_pkg::OP_ALLOC;
          case ($urandom_range(0, 19))
            0, 1:                   sz = '0;
            2:                      sz = '1;
            3, 4, 5:                sz = block_tbl[$urandom_range(0, NUM_BLOCKS - 1)];
            6, 7, 8, 9, 10, 11, 12: sz = SIZE_BITS'($urandom_range(1, 255));
            13, 14, 15, 16:         sz = SIZE_BITS'($urandom_range(0, 4095));
            default:                sz = SIZE_BITS'($urandom);
          endcase
        end
        send_item(op, idx, sz, 1'b0, '0);
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result receiver: random stalls plus one long hold-off
  initial begin
    bit hold_off_taken;
    hold_off_taken = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_go && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: found %0d chosen %0d remaining 0x%0h",
               found_o, chosen_block_o, remaining_size_o);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          fail_cnt++;
        end
        if (chosen_block_o !== want.chosen) begin
          $error("chosen_block: expected %0d, got %0d", want.chosen, chosen_block_o);
          fail_cnt++;
        end
        if (remaining_size_o !== want.rem) begin
          $error("remaining_size: expected 0x%0h, got 0x%0h", want.rem, remaining_size_o);
          fail_cnt++;
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
